### rtl/core/wind_vector_average_top_assert.svh
// Assertion macros shared by the wind vector average RTL
`ifndef WIND_VECTOR_AVERAGE_TOP_ASSERT_SVH
`define WIND_VECTOR_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define WVA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define WVA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wva_pkg.sv
// Types, constants and the arctangent table of the wind vector average
package wva_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int WORK_FRAC    = 24;

    localparam logic [15:0] INV_GAIN     = 16'd39797;
    localparam logic [14:0] FULL_TURN    = 15'd23040;
    localparam logic [15:0] WEIGHT_RESET = 16'd21823;

    // floor(w/45) = (w * RECIP45) >> 20 for w < 23040
    localparam logic [14:0] RECIP45       = 15'd23302;
    // floor(b * 2^23 / 45) = (b * FRAC45) >> 12 for b < 45
    localparam logic [29:0] FRAC45        = 30'd763549742;
    localparam logic [5:0]  DIV_BY        = 6'd45;

    localparam logic [31:0] QUARTER_TURN_BAM = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN_BAM    = 32'h8000_0000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [14:0] wrapped;
        logic [31:0] x0;
        logic [31:0] turn;
    } wva_item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_REM,
        F_ANG,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ROT,
        B_MULX_OLD,
        B_MULX_NEW,
        B_MULY_OLD,
        B_MULY_NEW,
        B_SAT_Y,
        B_VEC_LOAD,
        B_VEC,
        B_SCALE,
        B_FINISH,
        B_OUT
    } back_state_t;

    // atan(2^-i) as a binary angle, full turn = 2^32
    function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

### rtl/core/wva_front.sv
// Front end: wraps the angle, scales the speed and converts the angle to a binary angle
module wva_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [15:0]         wind_speed,
    input  logic signed [15:0]  wind_angle,
    output logic                q_push,
    output wva_pkg::wva_item_t  q_item,
    input  logic                q_full
);

    wva_pkg::front_state_t state_reg, state_next;

    logic [14:0] wrapped_reg, wrapped_next;
    logic [31:0] x0_reg, x0_next;
    logic [8:0]  quot_reg, quot_next;
    logic [5:0]  rem_reg, rem_next;
    logic [31:0] turn_reg, turn_next;

    logic signed [16:0] ang_ext;
    logic signed [16:0] ang_wrap;
    logic signed [16:0] ang_plus;
    logic [29:0]        quot_prod;
    logic [14:0]        rem_diff;
    logic [35:0]        frac_prod;

    // Wrap the raw angle into one turn
    always_comb
    begin
        ang_ext  = {wind_angle[15], wind_angle};
        ang_plus = ang_ext + 17'sd23040;
        if (ang_ext < 0)
        begin
            if (ang_plus < 0)
            begin
                ang_wrap = ang_ext + 17'sd46080;
            end
            else
            begin
                ang_wrap = ang_plus;
            end
        end
        else if (ang_ext >= 17'sd23040)
        begin
            ang_wrap = ang_ext - 17'sd23040;
        end
        else
        begin
            ang_wrap = ang_ext;
        end
    end

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wva_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the datapath registers
    always_ff @(posedge clk)
    begin
        wrapped_reg <= wrapped_next;
        x0_reg      <= x0_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        turn_reg    <= turn_next;
    end

    // Sequence the angle conversion: quotient, remainder, binary angle
    always_comb
    begin
        state_next   = state_reg;
        wrapped_next = wrapped_reg;
        x0_next      = x0_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        turn_next    = turn_reg;
        q_push       = 1'b0;
        quot_prod    = wrapped_reg * wva_pkg::RECIP45;
        rem_diff     = wrapped_reg - (15'(quot_reg) * 15'(wva_pkg::DIV_BY));
        frac_prod    = 36'(rem_reg) * 36'(wva_pkg::FRAC45);
        case (state_reg)
            wva_pkg::F_IDLE:
            begin
                if (push)
                begin
                    wrapped_next = ang_wrap[14:0];
                    x0_next      = wind_speed * wva_pkg::INV_GAIN;
                    state_next   = wva_pkg::F_DIV;
                end
            end
            wva_pkg::F_DIV:
            begin
                quot_next  = quot_prod[28:20];
                state_next = wva_pkg::F_REM;
            end
            wva_pkg::F_REM:
            begin
                rem_next   = rem_diff[5:0];
                state_next = wva_pkg::F_ANG;
            end
            wva_pkg::F_ANG:
            begin
                turn_next  = {quot_reg, 23'd0} + {8'd0, frac_prod[35:12]};
                state_next = wva_pkg::F_PUSH;
            end
            wva_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = wva_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = wva_pkg::F_IDLE;
            end
        endcase
    end

    assign full   = (state_reg != wva_pkg::F_IDLE);
    assign q_item = '{wrapped: wrapped_reg, x0: x0_reg, turn: turn_reg};

endmodule

### rtl/core/wva_queue.sv
// Short queue of prepared samples between front and back
`include "wind_vector_average_top_assert.svh"

module wva_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  wva_pkg::wva_item_t  wr_item,
    output logic                full,
    input  logic                rd_en,
    output wva_pkg::wva_item_t  rd_item,
    output logic                empty
);

    wva_pkg::wva_item_t entry_reg [wva_pkg::Q_DEPTH];

    logic [wva_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [wva_pkg::Q_CNT_W-1:0] count_reg;

    logic do_wr, do_rd;

    assign full  = (count_reg == wva_pkg::Q_CNT_W'(wva_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = entry_reg[rd_ptr_reg];

    `WVA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= wva_pkg::Q_CNT_W'(wva_pkg::Q_DEPTH), "queue count beyond depth")

endmodule

### rtl/core/wva_back.sv
// Back end: CORDIC rotation, weighted blend, CORDIC vectoring and result register
`include "wind_vector_average_top_assert.svh"

module wva_back #(
    parameter int CORDIC_STEPS    = 16,
    parameter int STATE_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         new_weight,
    input  logic                q_empty,
    output logic                q_pop,
    input  wva_pkg::wva_item_t  q_item,
    input  logic                pop,
    output logic                empty,
    output logic [14:0]         wrapped_angle,
    output logic [15:0]         average_speed,
    output logic [14:0]         average_angle
);

    localparam int N_STEPS = (CORDIC_STEPS > wva_pkg::ATAN_ENTRIES) ?
                             wva_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W  = $clog2(N_STEPS);
    localparam int DN      = wva_pkg::WORK_FRAC - STATE_FRAC_BITS;
    localparam int CW      = (29 + DN > 36) ? 29 + DN : 36;
    localparam int MA_W    = (36 - DN > 26) ? 36 - DN : 26;
    localparam int PW      = MA_W + 18;
    localparam int AW      = PW + 1;

    localparam logic [STEP_W-1:0]    LAST_STEP  = STEP_W'(N_STEPS - 1);
    localparam logic signed [AW-1:0] STATE_MAX  = 33554431;
    localparam logic signed [AW-1:0] STATE_MIN  = -33554432;
    localparam logic signed [AW-1:0] ROUND_HALF = 32768;

    wva_pkg::back_state_t state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0]   z_reg, z_next;
    logic signed [25:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [49:0]          mag_prod_reg, mag_prod_next;
    logic [46:0]          ang_prod_reg, ang_prod_next;
    logic                 base_reg, base_next;
    logic                 zero_reg, zero_next;
    logic [14:0]          wrapped_reg, wrapped_next;
    logic [14:0]          out_wrapped_reg, out_wrapped_next;
    logic [15:0]          out_speed_reg, out_speed_next;
    logic [14:0]          out_angle_reg, out_angle_next;

    logic signed [CW-1:0]   xs, ys, x0e, sx_full, vx, vy;
    logic [31:0]            atan_val;
    logic                   ccw;
    logic [31:0]            turn_fold;
    logic                   fold;
    logic signed [MA_W-1:0] mul_a;
    logic signed [17:0]     mul_b, w_new, w_old;
    logic signed [PW-1:0]   mul_p;
    logic signed [AW-1:0]   acc_sh;
    logic signed [25:0]     sat_val;
    logic [33:0]            xm;
    logic [31:0]            ang_bam;
    logic [34:0]            spd_sum;
    logic [47:0]            ang_sum;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wva_pkg::B_IDLE;
            step_reg  <= '0;
            ax_reg    <= '0;
            ay_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        y_reg           <= y_next;
        z_reg           <= z_next;
        prod_reg        <= prod_next;
        acc_reg         <= acc_next;
        mag_prod_reg    <= mag_prod_next;
        ang_prod_reg    <= ang_prod_next;
        base_reg        <= base_next;
        zero_reg        <= zero_next;
        wrapped_reg     <= wrapped_next;
        out_wrapped_reg <= out_wrapped_next;
        out_speed_reg   <= out_speed_next;
        out_angle_reg   <= out_angle_next;
    end

    // Shared CORDIC step, blend multiplier and saturation
    always_comb
    begin
        xs       = x_reg >>> step_reg;
        ys       = y_reg >>> step_reg;
        atan_val = wva_pkg::atan_entry(wva_pkg::ATAN_IDX_W'(step_reg));
        if (state_reg == wva_pkg::B_ROT)
        begin
            ccw = !z_reg[33];
        end
        else
        begin
            ccw = y_reg[CW-1] || (y_reg == '0);
        end

        x0e       = signed'({{(CW-32){1'b0}}, q_item.x0});
        fold      = ((q_item.turn - wva_pkg::QUARTER_TURN_BAM) < wva_pkg::HALF_TURN_BAM);
        turn_fold = fold ? (q_item.turn - wva_pkg::HALF_TURN_BAM) : q_item.turn;

        sx_full = x_reg >>> DN;
        w_new   = signed'({2'b00, new_weight});
        w_old   = 18'sd65536 - w_new;
        case (state_reg)
            wva_pkg::B_MULX_OLD:
            begin
                mul_a = MA_W'(ax_reg);
                mul_b = w_old;
            end
            wva_pkg::B_MULX_NEW:
            begin
                mul_a = MA_W'(sx_full);
                mul_b = w_new;
            end
            wva_pkg::B_MULY_OLD:
            begin
                mul_a = MA_W'(ay_reg);
                mul_b = w_old;
            end
            default:
            begin
                mul_a = MA_W'(y_reg >>> DN);
                mul_b = w_new;
            end
        endcase
        mul_p = mul_a * mul_b;

        acc_sh = acc_reg >>> 16;
        if (acc_sh > STATE_MAX)
        begin
            sat_val = 26'sh1FFFFFF;
        end
        else if (acc_sh < STATE_MIN)
        begin
            sat_val = 26'sh2000000;
        end
        else
        begin
            sat_val = acc_sh[25:0];
        end

        vx = CW'(ax_reg) <<< DN;
        vy = CW'(ay_reg) <<< DN;

        xm      = (|x_reg[CW-1:34]) ? '1 : x_reg[33:0];
        ang_bam = {base_reg, 31'd0} + z_reg[31:0];
        spd_sum = {1'b0, mag_prod_reg[49:16]} + 35'd32768;
        ang_sum = {1'b0, ang_prod_reg} + 48'h0000_8000_0000;
    end

    // Sequence one sample through rotate, blend, vector and scale
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        mag_prod_next    = mag_prod_reg;
        ang_prod_next    = ang_prod_reg;
        base_next        = base_reg;
        zero_next        = zero_reg;
        wrapped_next     = wrapped_reg;
        out_wrapped_next = out_wrapped_reg;
        out_speed_next   = out_speed_reg;
        out_angle_next   = out_angle_reg;
        q_pop            = 1'b0;
        case (state_reg)
            wva_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    wrapped_next = q_item.wrapped;
                    x_next       = fold ? -x0e : x0e;
                    y_next       = '0;
                    z_next       = signed'({{2{turn_fold[31]}}, turn_fold});
                    step_next    = '0;
                    state_next   = wva_pkg::B_ROT;
                end
            end
            wva_pkg::B_ROT, wva_pkg::B_VEC:
            begin
                if (ccw)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - signed'({2'b00, atan_val});
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + signed'({2'b00, atan_val});
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = (state_reg == wva_pkg::B_ROT) ? wva_pkg::B_MULX_OLD
                                                               : wva_pkg::B_SCALE;
                end
            end
            wva_pkg::B_MULX_OLD:
            begin
                prod_next  = mul_p;
                state_next = wva_pkg::B_MULX_NEW;
            end
            wva_pkg::B_MULX_NEW:
            begin
                acc_next   = AW'(prod_reg) + AW'(mul_p) + ROUND_HALF;
                state_next = wva_pkg::B_MULY_OLD;
            end
            wva_pkg::B_MULY_OLD:
            begin
                ax_next    = sat_val;
                prod_next  = mul_p;
                state_next = wva_pkg::B_MULY_NEW;
            end
            wva_pkg::B_MULY_NEW:
            begin
                acc_next   = AW'(prod_reg) + AW'(mul_p) + ROUND_HALF;
                state_next = wva_pkg::B_SAT_Y;
            end
            wva_pkg::B_SAT_Y:
            begin
                ay_next    = sat_val;
                state_next = wva_pkg::B_VEC_LOAD;
            end
            wva_pkg::B_VEC_LOAD:
            begin
                zero_next = (ax_reg == '0) && (ay_reg == '0);
                base_next = ax_reg[25];
                x_next    = ax_reg[25] ? -vx : vx;
                y_next    = ax_reg[25] ? -vy : vy;
                z_next    = '0;
                step_next = '0;
                if ((ax_reg == '0) && (ay_reg == '0))
                begin
                    state_next = wva_pkg::B_FINISH;
                end
                else
                begin
                    state_next = wva_pkg::B_VEC;
                end
            end
            wva_pkg::B_SCALE:
            begin
                mag_prod_next = 50'(xm) * 50'(wva_pkg::INV_GAIN);
                ang_prod_next = 47'(ang_bam) * 47'(wva_pkg::FULL_TURN);
                state_next    = wva_pkg::B_FINISH;
            end
            wva_pkg::B_FINISH:
            begin
                out_wrapped_next = wrapped_reg;
                if (zero_reg)
                begin
                    out_speed_next = '0;
                    out_angle_next = '0;
                end
                else
                begin
                    out_speed_next = (|spd_sum[34:32]) ? 16'hFFFF : spd_sum[31:16];
                    out_angle_next = (ang_sum[47:32] >= 16'(wva_pkg::FULL_TURN)) ?
                                     15'd0 : ang_sum[46:32];
                end
                state_next = wva_pkg::B_OUT;
            end
            wva_pkg::B_OUT:
            begin
                if (pop)
                begin
                    state_next = wva_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = wva_pkg::B_IDLE;
            end
        endcase
    end

    assign empty         = (state_reg != wva_pkg::B_OUT);
    assign wrapped_angle = out_wrapped_reg;
    assign average_speed = out_speed_reg;
    assign average_angle = out_angle_reg;

    `WVA_ASSERT_IMP(a_angle_range, clk, rst_n, state_reg == wva_pkg::B_OUT, out_angle_reg < wva_pkg::FULL_TURN, "average angle out of range")
    `WVA_ASSERT_IMP(a_zero_result, clk, rst_n, (state_reg == wva_pkg::B_OUT) && zero_reg, (out_speed_reg == '0) && (out_angle_reg == '0), "zero average gave nonzero result")
    `WVA_ASSERT_NXT(a_pop_starts_rot, clk, rst_n, q_pop, state_reg == wva_pkg::B_ROT, "popped word did not start rotation")

endmodule

### rtl/core/wind_vector_average_top.sv
// Top level of the wind vector average
//
//  channel   handshake            payload
//  input     push / full          wind_speed, wind_angle
//  result    pop / empty          wrapped_angle, average_speed, average_angle
//  config    cfg_we               cfg_wdata (new_weight)
//
// The front end takes one sample at a time (wrap, two reciprocal multiplies, push).
// In the back end one shared CORDIC unit runs the rotation and then the vectoring,
// one step per cycle, and one multiplier does the blend.
// A 2-word queue lets the front end take a new sample while the back end works.
// The back end holds its result until popped; the front end keeps filling the queue.
// Reset is asynchronous and active low; it clears the average and loads the weight.
module wind_vector_average_top #(
    parameter int CORDIC_STEPS    = 16,
    parameter int STATE_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        wind_speed,
    input  logic signed [15:0] wind_angle,
    input  logic               pop,
    output logic               empty,
    output logic [14:0]        wrapped_angle,
    output logic [15:0]        average_speed,
    output logic [14:0]        average_angle,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    logic [15:0] weight_reg;

    logic               fq_push, fq_full, bq_pop, bq_empty;
    wva_pkg::wva_item_t fq_item, bq_item;

    // Hold the new-sample weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= wva_pkg::WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            weight_reg <= cfg_wdata;
        end
    end

    wva_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .wind_speed (wind_speed),
        .wind_angle (wind_angle),
        .q_push     (fq_push),
        .q_item     (fq_item),
        .q_full     (fq_full)
    );

    wva_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_item (fq_item),
        .full    (fq_full),
        .rd_en   (bq_pop),
        .rd_item (bq_item),
        .empty   (bq_empty)
    );

    wva_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .new_weight    (weight_reg),
        .q_empty       (bq_empty),
        .q_pop         (bq_pop),
        .q_item        (bq_item),
        .pop           (pop),
        .empty         (empty),
        .wrapped_angle (wrapped_angle),
        .average_speed (average_speed),
        .average_angle (average_angle)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for the wind vector average block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS     = 16;
    localparam int FRAC_BITS = 16;
    localparam int WORK_FRAC = 24;
    localparam longint STATE_HI = 64'sd33554431;
    localparam longint STATE_LO = -64'sd33554432;
    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 1000;

    typedef struct packed {
        logic [14:0] wrapped;
        logic [15:0] speed;
        logic [14:0] angle;
    } wind_result_t;

    typedef struct {
        logic [15:0]        speed;
        logic signed [15:0] angle;
        logic               known;
        wind_result_t       res;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [15:0]        wind_speed;
    logic signed [15:0] wind_angle;
    logic               pop;
    logic               empty;
    logic [14:0]        wrapped_angle;
    logic [15:0]        average_speed;
    logic [14:0]        average_angle;
    logic               cfg_we;
    logic [15:0]        cfg_wdata;

    // predictor state
    logic [15:0] weight;
    longint      avg_x;
    longint      avg_y;

    wind_result_t expected_words[$];
    int           mismatches;
    bit           stim_done;
    bit           recv_stall;

    wind_vector_average_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .wind_speed    (wind_speed),
        .wind_angle    (wind_angle),
        .pop           (pop),
        .empty         (empty),
        .wrapped_angle (wrapped_angle),
        .average_speed (average_speed),
        .average_angle (average_angle),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // free-running clock, 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // arctangent of 2^-i as a binary angle
    function automatic longint arctan_step(input int i);
        logic [31:0] tab [0:23];
        tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return longint'(tab[i]);
    endfunction

    function automatic longint clamp_state(input longint v);
        if (v > STATE_HI)
            return STATE_HI;
        if (v < STATE_LO)
            return STATE_LO;
        return v;
    endfunction

    // advance the running average with one sample and return the word it yields
    function automatic wind_result_t average_wind(input logic [15:0] spd,
                                                  input logic signed [15:0] ang);
        wind_result_t r;
        int           wr;
        logic [31:0]  turn;
        longint       x, y, z, nx, ny, wn, wo, mag, ao;
        logic [31:0]  base;
        logic [63:0]  prod;
        int           dn;
        dn = WORK_FRAC - FRAC_BITS;
        wr = int'(ang) % 23040;
        if (wr < 0)
            wr += 23040;
        turn = 32'((64'(wr) << 32) / 64'd23040);
        // rotate (speed*gain, 0) by the sample angle
        x = longint'(spd) * 39797;
        y = 0;
        if (32'(turn - 32'h40000000) < 32'h80000000)
        begin
            x = -x;
            turn = turn - 32'h80000000;
        end
        z = longint'($signed(turn));
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
            end
            x = nx; y = ny;
        end
        x = x >>> dn;
        y = y >>> dn;
        // blend into the stored average
        wn = longint'(weight);
        wo = 65536 - wn;
        avg_x = clamp_state((avg_x * wo + x * wn + 32768) >>> 16);
        avg_y = clamp_state((avg_y * wo + y * wn + 32768) >>> 16);
        r.wrapped = 15'(wr);
        if (avg_x == 0 && avg_y == 0)
        begin
            r.speed = '0;
            r.angle = '0;
            return r;
        end
        // vectoring pass for magnitude and direction
        x = avg_x <<< dn;
        y = avg_y <<< dn;
        z = 0;
        base = '0;
        if (x < 0)
        begin
            x = -x; y = -y; base = 32'h80000000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
            end
            else
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
            end
            x = nx; y = ny;
        end
        mag = (x * 39797) >>> 16;
        mag = (mag + 32768) >>> 16;
        if (mag < 0)
            mag = 0;
        r.speed = (mag > 65535) ? 16'hFFFF : 16'(mag);
        prod = 64'(32'(base + 32'(z))) * 64'd23040 + 64'h80000000;
        ao = longint'(prod >> 32);
        if (ao >= 23040)
            ao = 0;
        r.angle = 15'(ao);
        return r;
    endfunction

    // send one word, with a random gap now and then to break up bursts
    task automatic send_word(input logic [15:0] spd, input logic signed [15:0] ang,
                             input bit idle_ok);
        if (idle_ok && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        push       <= 1'b1;
        wind_speed <= spd;
        wind_angle <= ang;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_words.push_back(average_wind(spd, ang));
        @(negedge clk);
    endtask

    // drain the pipeline, then write the weight while idle
    task automatic set_weight(input logic [15:0] w);
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
        weight = w;
    endtask

    // receiver stall pattern: long open stretches and busy spells
    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) < 3)
            recv_stall <= ~recv_stall;
        pop <= recv_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // compare each popped word with the oldest prediction
    always @(posedge clk)
    begin
        wind_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h %h %h",
                             wrapped_angle, average_speed, average_angle);
            end
            else
            begin
                want = expected_words.pop_front();
                if (want.wrapped !== wrapped_angle || want.speed !== average_speed
                    || want.angle !== average_angle)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: wrapped %0d/%0d speed %0d/%0d angle %0d/%0d",
                                 want.wrapped, wrapped_angle, want.speed, average_speed,
                                 want.angle, average_angle);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        stim_row_t    rows [N_DIRECTED];
        wind_result_t saved_res;
        longint       save_x, save_y;
        logic [15:0]  weights [4];
        push       = 1'b0;
        pop        = 1'b0;
        recv_stall = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        wind_speed = '0;
        wind_angle = '0;
        mismatches = 0;
        stim_done  = 1'b0;
        rst_n      = 1'b0;
        weight     = 16'd21823;
        avg_x      = 0;
        avg_y      = 0;
        // directed table: the zero-speed rows expect a zero average
        rows[0] = '{16'd0, 16'sd0, 1'b1, '{15'd0, 16'd0, 15'd0}};
        rows[1] = '{16'd0, -16'sd32768, 1'b1, '{15'd13312, 16'd0, 15'd0}};
        rows[2] = '{16'd0, 16'sd32767, 1'b1, '{15'd9727, 16'd0, 15'd0}};
        rows[3] = '{16'd0, -16'sd1, 1'b1, '{15'd23039, 16'd0, 15'd0}};
        rows[4] = '{16'd0, 16'sd23040, 1'b1, '{15'd0, 16'd0, 15'd0}};
        rows[5] = '{16'hFFFF, 16'sd0, 1'b0, '0};
        rows[6] = '{16'hFFFF, 16'sd5760, 1'b0, '0};
        rows[7] = '{16'hFFFF, 16'sd11520, 1'b0, '0};
        rows[8] = '{16'hFFFF, 16'sd17280, 1'b0, '0};
        rows[9] = '{16'hFFFF, 16'sd23039, 1'b0, '0};
        rows[10] = '{16'h0100, -16'sd32768, 1'b0, '0};
        rows[11] = '{16'h0100, 16'sd32767, 1'b0, '0};
        rows[12] = '{16'h0001, 16'sd1, 1'b0, '0};
        rows[13] = '{16'hAAAA, -16'sd23040, 1'b0, '0};
        rows[14] = '{16'h5555, 16'sd11519, 1'b0, '0};
        for (int i = 15; i < N_DIRECTED; i++)
            rows[i] = '{16'hFFFF, 16'sd0, 1'b0, '0};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // walk the directed table
        foreach (rows[i])
        begin
            save_x = avg_x;
            save_y = avg_y;
            saved_res = average_wind(rows[i].speed, rows[i].angle);
            avg_x = save_x;
            avg_y = save_y;
            if (rows[i].known && saved_res !== rows[i].res)
            begin
                mismatches++;
                $display("predictor disagrees on table row %0d", i);
            end
            send_word(rows[i].speed, rows[i].angle, 1'b0);
        end
        // weight extremes: all-new, all-old, then in between
        weights = '{16'hFFFF, 16'h0000, 16'h8000, 16'h1234};
        foreach (weights[p])
        begin
            set_weight(weights[p]);
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                logic [15:0] s;
                case ($urandom_range(0, 5))
                    0: s = 16'hFFFF - 16'($urandom_range(0, 3));
                    1: s = 16'($urandom_range(0, 4));
                    default: s = 16'($urandom);
                endcase
                send_word(s, 16'($urandom), 1'b1);
            end
        end
        set_weight(16'd21823);
        for (int n = 0; n < 30; n++)
            send_word(16'($urandom), 16'($urandom), 1'b1);
        push <= 1'b0;
        stim_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("wind_vector_average_top verification clean");
        else
            $display("wind_vector_average_top verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("wind_vector_average_top verification failed");
        $finish;
    end
endmodule
